// ----- sv/pbtl_pkg.sv -----
`default_nettype none

package pbtl_pkg;

  // Fixed geometry
  localparam int SEG_COUNT     = 256;
  localparam int SEG_AW        = 8;
  localparam int HANDLER_BITS  = 16;
  localparam int FPR_LSB       = 14;
  localparam int FPR_HIGH_BITS = 32 - FPR_LSB;

  // Input item kinds
  localparam logic [1:0] OP_SEG_WRITE   = 2'd0;
  localparam logic [1:0] OP_PAGE_WRITE  = 2'd1;
  localparam logic [1:0] OP_ENTRY_WRITE = 2'd2;
  localparam logic [1:0] OP_LOOKUP      = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_MISS       = 3'd0;
  localparam logic [2:0] ST_HIT        = 3'd1;
  localparam logic [2:0] ST_OVERRIDE_A = 3'd2;
  localparam logic [2:0] ST_OVERRIDE_B = 3'd3;
  localparam logic [2:0] ST_WRITE_DONE = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ENTRY_TOTAL = 2'd0;
  localparam logic [1:0] REG_OVERRIDE_A  = 2'd1;
  localparam logic [1:0] REG_OVERRIDE_B  = 2'd2;

  localparam logic [12:0] ENTRY_TOTAL_RST = 13'd0;
  localparam logic [31:0] OVERRIDE_A_RST  = 32'h8024_2D7C;
  localparam logic [31:0] OVERRIDE_B_RST  = 32'h8020_FF9C;

  typedef struct packed {
    logic        valid;
    logic [11:0] first_page;
    logic [12:0] page_count;
    logic [9:0]  page_base;
  } seg_word_t;

  typedef struct packed {
    logic [12:0] first_entry;
    logic [12:0] entry_count;
  } page_word_t;

  typedef struct packed {
    logic [31:0]               address;
    logic [HANDLER_BITS-1:0]   handler;
    logic                      preserve;
    logic [FPR_HIGH_BITS-1:0]  fpr_high;
  } entry_word_t;

endpackage

`default_nettype wire

// ----- sv/pbtl_ram.sv -----
`default_nettype none

module pbtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/paged_branch_target_lookup.sv -----
// Branch target lookup. Each input item is a write to one of the three tables
// (segment, page, entry) or a lookup of a 32-bit target. A lookup first checks
// the two override registers, then uses bits 31:24 to pick a segment, bits
// 23:12 as a page within it, and runs a lower-bound binary search over the
// page's slice of the sorted entry table; a match with a nonzero handler id is
// a hit. The block works on one item at a time: s_axis_tready is high only
// while it is idle, and a finished result sits in an output register so the
// next item can be taken while the result waits. A write passes through
// S_WRITE; an override, or a lookup with a zero entry total, is settled in
// S_SEG; a miss on the segment, page or range check is settled in S_PAGE or
// S_RANGE; a full lookup runs S_SEG, S_PAGE, S_RANGE, the S_SEARCH probes
// and S_FINAL. Each result then waits in S_EMIT until the output register is
// free, and the next item is accepted once the block is back in S_IDLE. The
// search rate is set by the single port of the entry memory, which serves one
// probe per cycle. The segment table starts out invalid after reset through
// per-segment valid flops; page and entry words must be written before a
// lookup reaches them. The user must write configuration over the APB port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module paged_branch_target_lookup
  import pbtl_pkg::*;
#(
  parameter int PAGE_SLOTS  = 1024,
  parameter int ENTRY_SLOTS = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata, low bit up: target_address[32], slot_index[12], seg_valid[1],
  // seg_first_page[12], seg_page_count[13], seg_page_base[10],
  // page_first_entry[13], page_entry_count[13], entry_handler[16],
  // entry_preserve_gprs[1], entry_fpr_mask[32], zero pad[5]
  input  wire logic [159:0] s_axis_tdata,
  // tuser: op[2]
  input  wire logic [1:0]   s_axis_tuser,
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata, low bit up: found_index[12], handler_id[16], preserve_gprs[1],
  // fpr_save_mask[32], zero pad[3]
  output logic      [63:0]  m_axis_tdata,
  // tuser: status[3]
  output logic      [2:0]   m_axis_tuser
);

  localparam int PAW = $clog2(PAGE_SLOTS);
  localparam int EAW = $clog2(ENTRY_SLOTS);
  localparam int PXW = (PAW > 13) ? PAW : 13;
  localparam int EXW = (EAW > 13) ? EAW : 13;
  localparam logic [12:0] TOTAL_CAP = (ENTRY_SLOTS > 8191) ? 13'h1FFF : 13'(ENTRY_SLOTS);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_SEG    = 3'd2;
  localparam logic [2:0] S_PAGE   = 3'd3;
  localparam logic [2:0] S_RANGE  = 3'd4;
  localparam logic [2:0] S_SEARCH = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [12:0] entry_total_q;
  logic [31:0] override_a_q;
  logic [31:0] override_b_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_total_q <= ENTRY_TOTAL_RST;
      override_a_q  <= OVERRIDE_A_RST;
      override_b_q  <= OVERRIDE_B_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ENTRY_TOTAL: entry_total_q <= pwdata[12:0];
        REG_OVERRIDE_A:  override_a_q  <= pwdata;
        REG_OVERRIDE_B:  override_b_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENTRY_TOTAL: prdata = {19'd0, entry_total_q};
      REG_OVERRIDE_A:  prdata = override_a_q;
      REG_OVERRIDE_B:  prdata = override_b_q;
      default:         prdata = 32'd0;
    endcase
  end

  // Clamp the entry total to the table depth
  logic [12:0] total_sat;
  assign total_sat = (entry_total_q > TOTAL_CAP) ? TOTAL_CAP : entry_total_q;

  // ---------------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------------
  logic [2:0]  state_q, state_d;
  logic        in_accept;
  logic [1:0]  op_q;
  logic [31:0] tgt_q;
  logic [11:0] slot_q;
  seg_word_t   seg_wdata_q;
  page_word_t  page_wdata_q;
  entry_word_t entry_wdata_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q                   <= s_axis_tuser;
      tgt_q                  <= s_axis_tdata[31:0];
      slot_q                 <= s_axis_tdata[43:32];
      seg_wdata_q.valid      <= s_axis_tdata[44];
      seg_wdata_q.first_page <= s_axis_tdata[56:45];
      seg_wdata_q.page_count <= s_axis_tdata[69:57];
      seg_wdata_q.page_base  <= s_axis_tdata[79:70];
      page_wdata_q.first_entry <= s_axis_tdata[92:80];
      page_wdata_q.entry_count <= s_axis_tdata[105:93];
      entry_wdata_q.address  <= s_axis_tdata[31:0];
      entry_wdata_q.handler  <= s_axis_tdata[121:106];
      entry_wdata_q.preserve <= s_axis_tdata[122];
      entry_wdata_q.fpr_high <= s_axis_tdata[154:123+FPR_LSB];
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic              seg_we, page_we, entry_we;
  logic [SEG_AW-1:0] seg_addr;
  logic [PAW-1:0]    page_addr;
  logic [EAW-1:0]    entry_addr;
  seg_word_t         seg_rd;
  page_word_t        page_rd;
  entry_word_t       entry_rd;

  pbtl_ram #(
    .WIDTH ($bits(seg_word_t)),
    .DEPTH (SEG_COUNT)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .addr_i  (seg_addr),
    .wdata_i (seg_wdata_q),
    .rdata_o (seg_rd)
  );

  pbtl_ram #(
    .WIDTH ($bits(page_word_t)),
    .DEPTH (PAGE_SLOTS)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .addr_i  (page_addr),
    .wdata_i (page_wdata_q),
    .rdata_o (page_rd)
  );

  pbtl_ram #(
    .WIDTH ($bits(entry_word_t)),
    .DEPTH (ENTRY_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_we),
    .addr_i  (entry_addr),
    .wdata_i (entry_wdata_q),
    .rdata_o (entry_rd)
  );

  // Per-segment written flags stand in for the reset-to-invalid segment table
  logic [SEG_COUNT-1:0] seg_written_q;
  logic                 seg_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_written_q <= '0;
    end else if (seg_we) begin
      seg_written_q[seg_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_hit_q <= seg_written_q[tgt_q[31:24]];
  end

  // ---------------------------------------------------------------------------
  // Segment and page checks
  // ---------------------------------------------------------------------------
  logic [11:0]    page_num, page_rel;
  logic [12:0]    page_idx;
  logic           page_idx_ok;
  logic [PXW-1:0] page_idx_x, page_slot_x;
  logic           page_slot_ok, entry_slot_ok, seg_slot_ok;
  logic [EXW-1:0] entry_slot_x, srch_idx_x;

  assign page_num     = tgt_q[23:12];
  assign page_rel     = page_num - seg_rd.first_page;
  assign page_idx     = 13'(seg_rd.page_base) + 13'(page_rel);
  assign page_idx_ok  = ({19'd0, page_idx} < 32'(PAGE_SLOTS));
  assign page_idx_x   = PXW'(page_idx);
  assign page_slot_x  = PXW'(slot_q);
  assign entry_slot_x = EXW'(slot_q);
  assign seg_slot_ok  = (slot_q[11:SEG_AW] == '0);
  assign page_slot_ok = ({20'd0, slot_q} < 32'(PAGE_SLOTS));
  assign entry_slot_ok = ({20'd0, slot_q} < 32'(ENTRY_SLOTS));

  // ---------------------------------------------------------------------------
  // Binary search step: fold in the probe that returned, pick the next address
  // ---------------------------------------------------------------------------
  logic [12:0] lo_q, lo_d, hi_q, hi_d, end_q, end_d, mid_q, mid_d;
  logic        probe_q, probe_d;
  logic [12:0] lo_n, hi_n, mid_n, srch_idx;

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (probe_q) begin
      if (entry_rd.address < tgt_q) begin
        lo_n = mid_q + 13'd1;
      end else begin
        hi_n = mid_q;
      end
    end
    mid_n    = lo_n + ((hi_n - lo_n) >> 1);
    srch_idx = (lo_n < hi_n) ? mid_n : lo_n;
  end

  assign srch_idx_x = EXW'(srch_idx);

  always_comb begin
    seg_addr   = (state_q == S_WRITE) ? slot_q[SEG_AW-1:0] : tgt_q[31:24];
    page_addr  = (state_q == S_WRITE) ? page_slot_x[PAW-1:0] : page_idx_x[PAW-1:0];
    entry_addr = (state_q == S_WRITE) ? entry_slot_x[EAW-1:0] : srch_idx_x[EAW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic        res_load;
  logic [2:0]  res_code;
  logic        emit;
  logic [2:0]  res_status_q;
  logic [11:0] res_index_q;
  logic [HANDLER_BITS-1:0] res_handler_q;
  logic        res_preserve_q;
  logic [31:0] res_fpr_q;

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    end_d    = end_q;
    mid_d    = mid_q;
    probe_d  = probe_q;
    seg_we   = 1'b0;
    page_we  = 1'b0;
    entry_we = 1'b0;
    res_load = 1'b0;
    res_code = ST_MISS;
    emit     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser == OP_LOOKUP) ? S_SEG : S_WRITE;
        end
      end

      S_WRITE: begin
        case (op_q)
          OP_SEG_WRITE:   seg_we   = seg_slot_ok;
          OP_PAGE_WRITE:  page_we  = page_slot_ok;
          OP_ENTRY_WRITE: entry_we = entry_slot_ok;
          default: ;
        endcase
        res_load = 1'b1;
        res_code = ST_WRITE_DONE;
        state_d  = S_EMIT;
      end

      // Segment word is being read; settle overrides and a disabled table now
      S_SEG: begin
        if (tgt_q == override_a_q) begin
          res_load = 1'b1;
          res_code = ST_OVERRIDE_A;
          state_d  = S_EMIT;
        end else if (tgt_q == override_b_q) begin
          res_load = 1'b1;
          res_code = ST_OVERRIDE_B;
          state_d  = S_EMIT;
        end else if (total_sat == 13'd0) begin
          res_load = 1'b1;
          state_d  = S_EMIT;
        end else begin
          state_d = S_PAGE;
        end
      end

      // Segment word in hand; page word read starts at page_idx
      S_PAGE: begin
        if (!seg_hit_q || !seg_rd.valid || (page_num < seg_rd.first_page) ||
            ({1'b0, page_rel} >= seg_rd.page_count) || !page_idx_ok) begin
          res_load = 1'b1;
          state_d  = S_EMIT;
        end else begin
          state_d = S_RANGE;
        end
      end

      S_RANGE: begin
        if ((page_rd.first_entry > total_sat) ||
            (page_rd.entry_count > (total_sat - page_rd.first_entry))) begin
          res_load = 1'b1;
          state_d  = S_EMIT;
        end else begin
          lo_d    = page_rd.first_entry;
          hi_d    = page_rd.first_entry + page_rd.entry_count;
          end_d   = page_rd.first_entry + page_rd.entry_count;
          probe_d = 1'b0;
          state_d = S_SEARCH;
        end
      end

      // One probe per cycle; the final read at the lower bound leaves for S_FINAL
      S_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d   = mid_n;
          probe_d = 1'b1;
        end else begin
          probe_d = 1'b0;
          if (lo_n < end_q) begin
            state_d = S_FINAL;
          end else begin
            res_load = 1'b1;
            state_d  = S_EMIT;
          end
        end
      end

      S_FINAL: begin
        res_load = 1'b1;
        if ((entry_rd.address == tgt_q) && (entry_rd.handler != '0)) begin
          res_code = ST_HIT;
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      probe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    end_q <= end_d;
    mid_q <= mid_d;
  end

  // Result hold; only a hit carries payload, and only S_FINAL can raise one
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= res_code;
      if (res_code == ST_HIT) begin
        res_index_q    <= lo_q[11:0];
        res_handler_q  <= entry_rd.handler;
        res_preserve_q <= entry_rd.preserve;
        res_fpr_q      <= {entry_rd.fpr_high, FPR_LSB'(0)};
      end else begin
        res_index_q    <= '0;
        res_handler_q  <= '0;
        res_preserve_q <= 1'b0;
        res_fpr_q      <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic [2:0]  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {3'd0, res_fpr_q, res_preserve_q, res_handler_q, res_index_q};
      m_user_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  // Search window stays ordered and inside the page's range
  a_window_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> ((lo_q <= hi_q) && (hi_q <= end_q)))
    else $error("search window out of order");

  // An outstanding probe lies inside the current window
  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && probe_q) |-> ((mid_q >= lo_q) && (mid_q < hi_q)))
    else $error("probe outside search window");

  // Only one item in flight: an accept closes the input until the result is queued
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while busy");

  // A hit never reports the empty handler id
  a_hit_has_handler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_HIT) |-> (m_axis_tdata[27:12] != '0))
    else $error("hit with zero handler");

  // Anything but a hit carries an all-zero payload
  a_nonhit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_HIT) |-> (m_axis_tdata == '0))
    else $error("non-hit result with payload");
`endif

endmodule

`default_nettype wire

// ----- test/paged_branch_target_lookup_test.sv -----
`timescale 1ns / 1ps

module paged_branch_target_lookup_test;
  import pbtl_pkg::*;

  // Table depths of the default build of the block.
  localparam int PAGE_DEPTH  = 1024;
  localparam int ENTRY_DEPTH = 4096;

  // One input item, field by field, at the widths of the stream.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] target;
    logic [11:0] slot;
    logic        seg_valid;
    logic [11:0] seg_first_page;
    logic [12:0] seg_page_count;
    logic [9:0]  seg_page_base;
    logic [12:0] page_first_entry;
    logic [12:0] page_entry_count;
    logic [15:0] entry_handler;
    logic        entry_preserve;
    logic [31:0] entry_fpr_mask;
  } lookup_req_t;

  // One result item.
  typedef struct {
    logic [2:0]  status;
    logic [11:0] found_index;
    logic [15:0] handler_id;
    logic        preserve;
    logic [31:0] fpr_mask;
  } lookup_resp_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [159:0]  s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;
  logic [2:0]    m_axis_tuser;

  // Shadow copy of the block's tables and registers. The write flags keep
  // the stimulus away from page and entry words that were never loaded.
  seg_word_t     seg_tbl [SEG_COUNT];
  page_word_t    page_tbl [PAGE_DEPTH];
  bit            page_set [PAGE_DEPTH];
  logic [31:0]   ent_addr [ENTRY_DEPTH];
  logic [15:0]   ent_handler [ENTRY_DEPTH];
  logic          ent_keep [ENTRY_DEPTH];
  logic [31:0]   ent_fpr [ENTRY_DEPTH];
  bit            ent_set [ENTRY_DEPTH];
  int            ent_list[$];
  logic [12:0]   cfg_total;
  logic [31:0]   cfg_ovr_a;
  logic [31:0]   cfg_ovr_b;

  // Items waiting to be offered, with the result each one must produce, and
  // results of accepted items that have not come back yet.
  lookup_req_t   queued_items[$];
  lookup_resp_t  queued_results[$];
  lookup_resp_t  pending_results[$];

  lookup_req_t   drive_item;
  lookup_resp_t  offered_result;
  lookup_resp_t  seen_expect;
  int            errors = 0;
  int            accepted_count = 0;
  int            entry_cursor = 0;
  int            send_gap = 0;
  int            hold_gap = 0;
  bit            calm = 1'b0;
  logic          squeeze = 1'b0;

  always #5 clk_i = ~clk_i;

  paged_branch_target_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one item to the shadow tables and work out its result. Returns 0,
  // leaving the tables untouched, when a lookup would read a page or entry
  // word that was never written; such an item must not be sent.
  function automatic bit resolve_item(input lookup_req_t r, output lookup_resp_t o);
    seg_word_t  sg;
    page_word_t pw;
    int total, page, rel, pidx, first, count, lo, hi, mid, last;
    o = '{default: '0};
    case (r.op)
      OP_SEG_WRITE: begin
        if (r.slot < SEG_COUNT)
          seg_tbl[r.slot] = '{r.seg_valid, r.seg_first_page, r.seg_page_count,
                              r.seg_page_base};
        o.status = ST_WRITE_DONE;
      end
      OP_PAGE_WRITE: begin
        if (r.slot < PAGE_DEPTH) begin
          page_tbl[r.slot] = '{r.page_first_entry, r.page_entry_count};
          page_set[r.slot] = 1'b1;
        end
        o.status = ST_WRITE_DONE;
      end
      OP_ENTRY_WRITE: begin
        if (!ent_set[r.slot]) ent_list.push_back(r.slot);
        ent_set[r.slot]     = 1'b1;
        ent_addr[r.slot]    = r.target;
        ent_handler[r.slot] = r.entry_handler;
        ent_keep[r.slot]    = r.entry_preserve;
        ent_fpr[r.slot]     = {r.entry_fpr_mask[31:FPR_LSB], {FPR_LSB{1'b0}}};
        o.status = ST_WRITE_DONE;
      end
      default: begin
        if (r.target == cfg_ovr_a) begin
          o.status = ST_OVERRIDE_A;
        end else if (r.target == cfg_ovr_b) begin
          o.status = ST_OVERRIDE_B;
        end else begin
          o.status = ST_MISS;
          // a total beyond the table saturates to the table size
          total = (cfg_total > ENTRY_DEPTH) ? ENTRY_DEPTH : int'(cfg_total);
          sg    = seg_tbl[r.target[31:24]];
          page  = r.target[23:12];
          if (total == 0 || !sg.valid || page < int'(sg.first_page)) return 1'b1;
          rel = page - int'(sg.first_page);
          if (rel >= int'(sg.page_count)) return 1'b1;
          pidx = int'(sg.page_base) + rel;
          if (pidx >= PAGE_DEPTH) return 1'b1;
          if (!page_set[pidx]) return 1'b0;
          pw    = page_tbl[pidx];
          first = pw.first_entry;
          count = pw.entry_count;
          if (first > total || count > total - first) return 1'b1;
          // lower-bound search over the page's slice of the entry table
          lo   = first;
          last = first + count;
          hi   = last;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (!ent_set[mid]) return 1'b0;
            if (ent_addr[mid] < r.target) lo = mid + 1;
            else hi = mid;
          end
          if (lo < last) begin
            if (!ent_set[lo]) return 1'b0;
            // an exact match with no handler stays a miss
            if (ent_addr[lo] == r.target && ent_handler[lo] != '0) begin
              o.status      = ST_HIT;
              o.found_index = lo[11:0];
              o.handler_id  = ent_handler[lo];
              o.preserve    = ent_keep[lo];
              o.fpr_mask    = ent_fpr[lo];
            end
          end
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Queue an item with its result; drop it if it is not safe to send.
  function automatic bit enqueue(input lookup_req_t it);
    lookup_resp_t res;
    if (!resolve_item(it, res)) return 1'b0;
    queued_items.push_back(it);
    queued_results.push_back(res);
    return 1'b1;
  endfunction

  // Every field random, so that unused fields toggle too.
  function automatic lookup_req_t random_item(input logic [1:0] op);
    lookup_req_t it;
    it.op               = op;
    it.target           = $urandom;
    it.slot             = 12'($urandom_range(0, 4095));
    it.seg_valid        = 1'($urandom_range(0, 1));
    it.seg_first_page   = 12'($urandom_range(0, 4095));
    it.seg_page_count   = 13'($urandom_range(0, 4096));
    it.seg_page_base    = 10'($urandom_range(0, 1023));
    it.page_first_entry = 13'($urandom_range(0, 4096));
    it.page_entry_count = 13'($urandom_range(0, 4096));
    it.entry_handler    = 16'($urandom_range(0, 65535));
    it.entry_preserve   = 1'($urandom_range(0, 1));
    it.entry_fpr_mask   = $urandom;
    return it;
  endfunction

  function automatic bit push_lookup(input logic [31:0] addr);
    lookup_req_t it;
    it = random_item(OP_LOOKUP);
    it.target = addr;
    return enqueue(it);
  endfunction

  function automatic bit push_segment(input int slot, input logic valid, input int first_page,
                                      input int page_count, input int page_base);
    lookup_req_t it;
    it = random_item(OP_SEG_WRITE);
    it.slot           = 12'(slot);
    it.seg_valid      = valid;
    it.seg_first_page = 12'(first_page);
    it.seg_page_count = 13'(page_count);
    it.seg_page_base  = 10'(page_base);
    return enqueue(it);
  endfunction

  function automatic bit push_page(input int slot, input int first_entry, input int count);
    lookup_req_t it;
    it = random_item(OP_PAGE_WRITE);
    it.slot             = 12'(slot);
    it.page_first_entry = 13'(first_entry);
    it.page_entry_count = 13'(count);
    return enqueue(it);
  endfunction

  function automatic bit push_entry(input int slot, input logic [31:0] addr,
                                    input logic [15:0] handler, input logic keep,
                                    input logic [31:0] mask);
    lookup_req_t it;
    it = random_item(OP_ENTRY_WRITE);
    it.slot           = 12'(slot);
    it.target         = addr;
    it.entry_handler  = handler;
    it.entry_preserve = keep;
    it.entry_fpr_mask = mask;
    return enqueue(it);
  endfunction

  function automatic logic [31:0] known_address();
    return ent_addr[ent_list[$urandom_range(0, ent_list.size() - 1)]];
  endfunction

  // Lay out one segment with a few pages, each page over a sorted run of
  // fresh entries: entries first, then pages, then the segment itself.
  task automatic build_region(output int emitted);
    int pages, per, first_page, base, first, step, low;
    logic [7:0]  seg;
    logic [11:0] pg;
    logic [15:0] handler;
    seg        = 8'($urandom_range(0, 255));
    pages      = $urandom_range(1, 3);
    first_page = $urandom_range(0, 4096 - pages);
    // now and then let the last page fall past the end of the page table
    base = ($urandom_range(0, 9) == 0) ? 1025 - pages : $urandom_range(0, 1024 - pages);
    emitted = 0;
    for (int p = 0; p < pages; p++) begin
      per = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 8);
      if (entry_cursor + per > ENTRY_DEPTH) entry_cursor = 0;
      first = entry_cursor;
      entry_cursor += per;
      step = 4095 / (per + 1);
      low  = 0;
      pg   = 12'(first_page + p);
      for (int k = 0; k < per; k++) begin
        low += $urandom_range(0, step);
        handler = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
        emitted += push_entry(first + k, {seg, pg, low[11:0]}, handler,
                              1'($urandom_range(0, 1)), $urandom);
      end
      emitted += push_page(base + p, first, per);
    end
    emitted += push_segment(seg, 1'b1, first_page, pages, base);
  endtask

  // Mostly lookups aimed at loaded entries, plus fresh layouts, near misses,
  // overrides, random addresses and stray writes.
  task automatic queue_random_items(input int count);
    int made, r, inc;
    logic [31:0] addr, base_addr;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        build_region(inc);
        made += inc;
      end else begin
        if (r < 55) begin
          addr = known_address();
        end else if (r < 65) begin
          addr = known_address() + 32'($urandom_range(0, 1) ? 1 : -1);
        end else if (r < 75) begin
          base_addr = known_address();
          addr = {base_addr[31:12], 12'($urandom_range(0, 4095))};
        end else if (r < 80) begin
          addr = $urandom_range(0, 1) ? cfg_ovr_a : cfg_ovr_b;
        end else begin
          addr = $urandom;
        end
        if (r < 90) made += push_lookup(addr);
        else made += enqueue(random_item(2'($urandom_range(0, 2))));
      end
    end
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENTRY_TOTAL: cfg_total = value[12:0];
      REG_OVERRIDE_A:  cfg_ovr_a = value;
      REG_OVERRIDE_B:  cfg_ovr_b = value;
      default: ;
    endcase
  endtask

  // Wait until every queued item went in and every result came back.
  task automatic settle();
    do @(negedge clk_i);
    while (queued_items.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Driver: hold the item until it is taken, then wait out a random gap and
  // offer the next one from the queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(offered_result);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_items.size() > 0) begin
          drive_item     = queued_items.pop_front();
          offered_result = queued_results.pop_front();
          s_axis_tvalid  <= 1'b1;
          s_axis_tdata   <= {5'b0, drive_item.entry_fpr_mask, drive_item.entry_preserve,
                             drive_item.entry_handler, drive_item.page_entry_count,
                             drive_item.page_first_entry, drive_item.seg_page_base,
                             drive_item.seg_page_count, drive_item.seg_first_page,
                             drive_item.seg_valid, drive_item.slot, drive_item.target};
          s_axis_tuser   <= drive_item.op;
          send_gap = calm ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest outstanding one and
  // stall the output side at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with no item outstanding, expected none, got status %0d",
                   $time, m_axis_tuser);
        end else begin
          seen_expect = pending_results.pop_front();
          check_field("status", seen_expect.status, m_axis_tuser);
          check_field("found_index", seen_expect.found_index, m_axis_tdata[11:0]);
          check_field("handler_id", seen_expect.handler_id, m_axis_tdata[27:12]);
          check_field("preserve_gprs", seen_expect.preserve, m_axis_tdata[28]);
          check_field("fpr_save_mask", seen_expect.fpr_mask, m_axis_tdata[60:29]);
        end
      end
      if (squeeze) begin
        m_axis_tready <= 1'b0;
      end else if (hold_gap > 0) begin
        hold_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold_gap = pick_gap();
      end
    end
  end

  // Long receiver hold-off once traffic is flowing, so the result register
  // fills and the block backs up onto its input while the driver keeps
  // offering items.
  initial begin
    while (accepted_count < 200) @(negedge clk_i);
    @(posedge clk_i);
    squeeze <= 1'b1;
    repeat (300) @(posedge clk_i);
    squeeze <= 1'b0;
  end

  initial begin : stimulus
    int          items;
    logic [31:0] total_val, pin_a, pin_b;
    for (int s = 0; s < SEG_COUNT; s++) seg_tbl[s] = '0;
    cfg_total = ENTRY_TOTAL_RST;
    cfg_ovr_a = OVERRIDE_A_RST;
    cfg_ovr_b = OVERRIDE_B_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: overrides answer, everything else misses on a zero
    // total. Out-of-range segment and page slots are dropped.
    void'(push_lookup(OVERRIDE_A_RST));
    void'(push_lookup(OVERRIDE_B_RST));
    void'(push_lookup(32'h0000_0000));
    void'(push_lookup(32'hFFFF_FFFF));
    void'(push_segment(4095, 1'b1, 4095, 4096, 1023));
    void'(push_page(4095, 4096, 4096));
    void'(push_entry(4095, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    settle();

    // Full table: a range that ends right at the total, hits at both ends,
    // an entry shadowed by override A, a handler of zero, a gap between
    // entries, pages outside the segment and past the page table.
    write_reg(REG_ENTRY_TOTAL, 32'd4096);
    void'(push_entry(4092, 32'h8024_2000, 16'h0001, 1'b0, 32'h0000_0000));
    void'(push_entry(4093, 32'h8024_2D7C, 16'h1234, 1'b1, 32'h0000_3FFF));
    void'(push_entry(4094, 32'h8024_2E00, 16'h0000, 1'b1, 32'hFFFF_FFFF));
    void'(push_entry(4095, 32'h8024_2FFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    void'(push_page(1023, 4092, 4));
    void'(push_segment(8'h80, 1'b1, 12'h242, 1, 1023));
    void'(push_segment(8'h81, 1'b1, 0, 4096, 1023));
    void'(push_lookup(32'h8024_2000));
    void'(push_lookup(32'h8024_2D7C));
    void'(push_lookup(32'h8024_2E00));
    void'(push_lookup(32'h8024_2FFF));
    void'(push_lookup(32'h8024_2001));
    void'(push_lookup(32'h8024_3000));
    void'(push_lookup(32'h8024_1FFF));
    void'(push_lookup(32'h8100_1000));
    void'(push_lookup(32'h0500_0000));
    settle();

    // Range now one past the total, then a total that saturates.
    write_reg(REG_ENTRY_TOTAL, 32'd4095);
    void'(push_lookup(32'h8024_2FFF));
    settle();
    write_reg(REG_ENTRY_TOTAL, 32'h0000_1FFF);
    void'(push_lookup(32'h8024_2FFF));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      calm = 1'b0;
      case (ph)
        0: begin
          total_val = 4096; pin_a = OVERRIDE_A_RST; pin_b = OVERRIDE_B_RST;
          items = 100; calm = 1'b1;
        end
        1: begin
          total_val = $urandom_range(1, 4096); pin_a = $urandom; pin_b = $urandom;
          items = 160;
        end
        2: begin
          total_val = 4096; pin_a = 32'h0000_0000; pin_b = 32'hFFFF_FFFF;
          items = 150;
        end
        3: begin
          total_val = $urandom_range(2048, 4096); pin_a = known_address();
          pin_b = known_address(); items = 100;
        end
        4: begin
          total_val = 32'h1FFF; pin_a = 32'hFFFF_FFFF; pin_b = 32'h0000_0000;
          items = 120;
        end
        default: begin
          // zero total, and both overrides on the same address
          total_val = 0; pin_a = known_address(); pin_b = pin_a;
          items = 30;
        end
      endcase
      write_reg(REG_ENTRY_TOTAL, total_val);
      write_reg(REG_OVERRIDE_A, pin_a);
      write_reg(REG_OVERRIDE_B, pin_b);
      queue_random_items(items);
      settle();
    end

    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("paged_branch_target_lookup_test: done, clean");
    end else begin
      $display("paged_branch_target_lookup_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("paged_branch_target_lookup_test: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
sv/pbtl_pkg.sv
sv/pbtl_ram.sv
sv/paged_branch_target_lookup.sv
test/paged_branch_target_lookup_test.sv
